// ===== rtl/mts_pkg.sv =====
package mts_pkg;

   localparam int STACK_DEPTH_DEFAULT = 1024;
   localparam int VALUE_W             = 32;
   localparam int COUNT_W             = 11;

   localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7fff_ffff;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      command_type                command;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  top_value;
      logic signed [VALUE_W-1:0]  min_value;
      logic [COUNT_W-1:0]         entry_count;
      logic                       is_empty;
      status_type                 status;
   } rsp_type;

   // one stack level: stored value and running minimum at or below it
   typedef struct packed {
      logic signed [VALUE_W-1:0]  value;
      logic signed [VALUE_W-1:0]  min_val;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

endpackage

// ===== rtl/mts_cell.sv =====
module mts_cell (
   input  logic                clock,
   input  mts_pkg::shift_type  shift,
   input  mts_pkg::entry_type  up_in,
   input  mts_pkg::entry_type  down_in,
   output mts_pkg::entry_type  entry
);

   mts_pkg::entry_type entry_ff;
   mts_pkg::entry_type entry_in;

   always_comb begin
      if (shift.push) begin
         entry_in = up_in;
      end else if (shift.pop) begin
         entry_in = down_in;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/min_tracking_stack_top.sv =====
// response: the rsp beat of an accepted req beat is registered and valid in the cycle after it
// throughput: one push or pop per cycle while req_stall is low; each operation moves the
// whole row of cells by at most one level, with the top of stack in cell zero
// reset: clears the entry count and the rsp valid; cell contents are not
// cleared since a level is only read after a push has filled it
module min_tracking_stack_top #(
   parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mts_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mts_pkg::rsp_type  rsp_payload
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int EXT_W = CNT_W + mts_pkg::COUNT_W;

   mts_pkg::entry_type entry_q [STACK_DEPTH];
   mts_pkg::entry_type new_entry;
   mts_pkg::shift_type shift;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   mts_pkg::rsp_type   rsp_data_ff;
   mts_pkg::rsp_type   rsp_data_in;

   logic               accept;
   logic               is_push;
   logic               full;
   logic               empty;
   logic signed [mts_pkg::VALUE_W-1:0] below_min;
   logic [EXT_W-1:0]   count_ext;
   mts_pkg::entry_type top_next;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_push   = (req_payload.command == mts_pkg::CMD_PUSH);
   assign full      = (count_ff == CNT_W'(STACK_DEPTH));
   assign empty     = (count_ff == '0);

   assign shift.push = accept && is_push && !full;
   assign shift.pop  = accept && !is_push && !empty;

   assign below_min         = empty ? mts_pkg::INT_MAX : entry_q[0].min_val;
   assign new_entry.value   = req_payload.value;
   assign new_entry.min_val = (req_payload.value < below_min) ? req_payload.value : below_min;

   genvar i;
   generate
      for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
         mts_pkg::entry_type up_in;
         mts_pkg::entry_type down_in;
         if (i == 0) begin : g_first
            assign up_in = new_entry;
         end else begin : g_up
            assign up_in = entry_q[i-1];
         end
         if (i == STACK_DEPTH - 1) begin : g_last
            assign down_in = entry_q[i];
         end else begin : g_down
            assign down_in = entry_q[i+1];
         end
         mts_cell u_cell (
            .clock   (clock),
            .shift   (shift),
            .up_in   (up_in),
            .down_in (down_in),
            .entry   (entry_q[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      top_next = entry_q[0];
      if (shift.push) begin
         count_in = count_ff + CNT_W'(1);
         top_next = new_entry;
      end else if (shift.pop) begin
         count_in = count_ff - CNT_W'(1);
         top_next = entry_q[1];
      end
   end

   assign count_ext = EXT_W'(count_in);

   always_comb begin
      rsp_data_in.entry_count = count_ext[mts_pkg::COUNT_W-1:0];
      rsp_data_in.is_empty    = (count_in == '0);
      if (count_in == '0) begin
         rsp_data_in.top_value = '0;
         rsp_data_in.min_value = mts_pkg::INT_MAX;
      end else begin
         rsp_data_in.top_value = top_next.value;
         rsp_data_in.min_value = top_next.min_val;
      end
      if (is_push && full) begin
         rsp_data_in.status = mts_pkg::STATUS_FULL;
      end else if (!is_push && empty) begin
         rsp_data_in.status = mts_pkg::STATUS_EMPTY;
      end else begin
         rsp_data_in.status = mts_pkg::STATUS_OK;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("entry count beyond stack depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      shift.push |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("accepted push did not bump the count");

   a_push_top: assert property (@(posedge clock) disable iff (reset)
      shift.push |=> entry_q[0].value == $past(req_payload.value))
      else $error("pushed value not at top cell");

   a_min_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> entry_q[0].min_val <= entry_q[0].value)
      else $error("running minimum above top value");

   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !shift.push && !shift.pop) |=> count_ff == $past(count_ff))
      else $error("rejected beat changed the count");
`endif

endmodule
